// File: rtl/core/ppsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ppsm_pkg;

	// Field and register widths
	localparam int COUNT_WIDTH = 32;
	localparam int TICK_W      = 32;
	localparam int TIMEOUT_W   = 16;
	localparam int PPK_W       = 20;
	localparam int TIME_W      = 32;
	localparam int FREQ_W      = 32;
	localparam int OUT_W       = 16;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_IDX_W   = 2;

	// Serial divider sizing
	localparam int DIV_W   = 44;
	localparam int DVS_W   = 32;
	localparam int STEP_W  = 6;
	localparam int NUM_W   = 39;
	localparam int FILT_W  = 35;

	// Register reset values
	localparam logic [TICK_W-1:0]    TICK_RESET    = TICK_W'(1000000);
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(1000);
	localparam logic [PPK_W-1:0]     PPK_RESET     = PPK_W'(1000);

	localparam logic [DVS_W-1:0] FILT_DIVISOR = DVS_W'(5);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PPK       = 2'd2;

	// Item kinds
	localparam logic OP_CAPTURE = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_RAW_WAIT,
		ST_FILT_GO,
		ST_FILT_WAIT,
		ST_SPEED_GO,
		ST_SPEED_WAIT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [DIV_W-1:0]  dividend;
		logic [DVS_W-1:0]  divisor;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic [TICK_W-1:0]    tick_rate_hz;
		logic [TIMEOUT_W-1:0] timeout_ms;
		logic [PPK_W-1:0]     pulses_per_km;
	} cfg_t;

	typedef struct packed {
		logic [OUT_W-1:0] freq_chz;
		logic [OUT_W-1:0] speed_ckph;
		logic             has_signal;
	} res_t;

	function automatic logic [OUT_W-1:0] clamp16(input logic [DIV_W-1:0] v);
		clamp16 = (|v[DIV_W-1:OUT_W]) ? {OUT_W{1'b1}} : v[OUT_W-1:0];
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/pulse_period_speed_meter.sv
// Capture edges give no result; the next item is taken in the next cycle.
// A request with no signal gives a zero result; without a new period only the speed division runs.
// A request with a new period runs three divisions, one quotient bit per cycle in the shared serial
// divider (39 + 35 + 44 steps); it skips the filter division when it loads a cleared filter.
// Requests are handled one at a time; the output register lets the next item in while
// a result waits. Asynchronous active-low reset clears control and measurement state and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none
module pulse_period_speed_meter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,  // capture_value[31:0], now_ms[63:32]
	input  wire logic        s_tuser,  // op
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // freq_chz[15:0], speed_ckph[31:16]
	output logic             m_tuser,  // has_signal
	input  wire logic        cfg_we,
	input  wire logic [ppsm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ppsm_pkg::CFG_DATA_W-1:0] cfg_data
);

	ppsm_pkg::cfg_t cfg_q;
	ppsm_pkg::res_t res;
	logic           res_valid;
	logic           res_ready;
	logic           m_tvalid_q;
	logic [31:0]    m_tdata_q;
	logic           m_tuser_q;

	// Register writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_rate_hz  <= ppsm_pkg::TICK_RESET;
			cfg_q.timeout_ms    <= ppsm_pkg::TIMEOUT_RESET;
			cfg_q.pulses_per_km <= ppsm_pkg::PPK_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ppsm_pkg::CFG_TICK_RATE:
					cfg_q.tick_rate_hz <= cfg_data[ppsm_pkg::TICK_W-1:0];
				ppsm_pkg::CFG_TIMEOUT:
					cfg_q.timeout_ms <= cfg_data[ppsm_pkg::TIMEOUT_W-1:0];
				ppsm_pkg::CFG_PPK:
					cfg_q.pulses_per_km <= cfg_data[ppsm_pkg::PPK_W-1:0];
				default: ;
			endcase
		end
	end

	// Output register: load a finished result when the slot is free
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (res_valid && res_ready)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_tdata_q <= {res.speed_ckph, res.freq_chz};
			m_tuser_q <= res.has_signal;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	ppsm_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_op      (s_tuser),
		.in_capture (s_tdata[ppsm_pkg::COUNT_WIDTH-1:0]),
		.in_now     (s_tdata[63:32]),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// A no-signal result carries zeros
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("no-signal result with nonzero data");

	// A request holds off further items while it is worked on
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == ppsm_pkg::OP_REQUEST |=> !s_tready)
		else $error("input taken during request processing");

	// A new result appears only after the sequencer offered one
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(res_valid))
		else $error("result without request");

endmodule
`default_nettype wire

// File: rtl/core/ppsm_div.sv
`timescale 1ns / 1ps
`default_nettype none
module ppsm_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire ppsm_pkg::div_req_t             req,
	output logic                                done,
	output logic [ppsm_pkg::DIV_W-1:0]          quotient
);

	logic [ppsm_pkg::DIV_W-1:0]  work_q;
	logic [ppsm_pkg::DVS_W-1:0]  rem_q;
	logic [ppsm_pkg::DVS_W-1:0]  divisor_q;
	logic [ppsm_pkg::STEP_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [ppsm_pkg::DVS_W:0]    trial;
	logic [ppsm_pkg::DVS_W:0]    diff;
	logic                        fits;

	// Bring down the next dividend bit and try the subtraction
	always_comb begin
		trial = {rem_q, work_q[ppsm_pkg::DIV_W-1]};
		diff  = trial - {1'b0, divisor_q};
		fits  = (trial >= {1'b0, divisor_q});
	end

	// Control: load on start, count one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ppsm_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: dividend shifts out the top, quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			work_q    <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			work_q <= {work_q[ppsm_pkg::DIV_W-2:0], fits};
			rem_q  <= fits ? diff[ppsm_pkg::DVS_W-1:0] : trial[ppsm_pkg::DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = work_q;

endmodule
`default_nettype wire

// File: rtl/core/ppsm_seq.sv
`timescale 1ns / 1ps
`default_nettype none
module ppsm_seq (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire ppsm_pkg::cfg_t                 cfg,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           in_op,
	input  wire logic [ppsm_pkg::COUNT_WIDTH-1:0] in_capture,
	input  wire logic [ppsm_pkg::TIME_W-1:0]    in_now,
	output logic                                res_valid,
	input  wire logic                           res_ready,
	output ppsm_pkg::res_t                      res
);

	ppsm_pkg::state_t state_q, state_next;

	logic                             armed_q;
	logic [ppsm_pkg::COUNT_WIDTH-1:0] prev_capture_q;
	logic [ppsm_pkg::COUNT_WIDTH-1:0] period_q;
	logic [ppsm_pkg::TIME_W-1:0]      capture_time_q;
	logic                             pending_q;
	logic [ppsm_pkg::FREQ_W-1:0]      filtered_q;
	logic                             loaded_q;
	logic [ppsm_pkg::TIME_W-1:0]      now_q;
	logic [ppsm_pkg::FREQ_W-1:0]      raw_q;
	ppsm_pkg::res_t                   res_q;

	logic                             accept;
	logic                             lost;
	logic [ppsm_pkg::FREQ_W-1:0]      raw_sat;
	logic [ppsm_pkg::NUM_W-1:0]       raw_num;
	logic [ppsm_pkg::FILT_W-1:0]      filt_sum;
	logic [ppsm_pkg::PPK_W-1:0]       ppk_eff;
	logic [ppsm_pkg::DIV_W-1:0]       speed_num;
	logic                             div_start;
	ppsm_pkg::div_req_t               div_req;
	logic                             div_done;
	logic [ppsm_pkg::DIV_W-1:0]       div_quot;

	assign accept = in_valid && in_ready;

	// Signal loss: no period yet, or the last capture is too old
	assign lost = (period_q == '0) ||
		((now_q - capture_time_q) > ppsm_pkg::TIME_W'(cfg.timeout_ms));

	// Dividends of the three divisions, effective pulses per km and saturated raw frequency
	always_comb begin
		raw_num = (ppsm_pkg::NUM_W'(cfg.tick_rate_hz) << 6)
			+ (ppsm_pkg::NUM_W'(cfg.tick_rate_hz) << 5)
			+ (ppsm_pkg::NUM_W'(cfg.tick_rate_hz) << 2)
			+ ppsm_pkg::NUM_W'(period_q >> 1);
		filt_sum = (ppsm_pkg::FILT_W'(filtered_q) << 2)
			+ ppsm_pkg::FILT_W'(raw_q) + ppsm_pkg::FILT_W'(2);
		ppk_eff = (cfg.pulses_per_km == '0) ? ppsm_pkg::PPK_W'(1) : cfg.pulses_per_km;
		speed_num = (ppsm_pkg::DIV_W'(filtered_q) << 12)
			- (ppsm_pkg::DIV_W'(filtered_q) << 9)
			+ (ppsm_pkg::DIV_W'(filtered_q) << 4)
			+ ppsm_pkg::DIV_W'(ppk_eff >> 1);
		raw_sat = (|div_quot[ppsm_pkg::DIV_W-1:ppsm_pkg::FREQ_W]) ?
			{ppsm_pkg::FREQ_W{1'b1}} : div_quot[ppsm_pkg::FREQ_W-1:0];
	end

	// Next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ppsm_pkg::ST_IDLE: begin
				if (accept && in_op == ppsm_pkg::OP_REQUEST)
					state_next = ppsm_pkg::ST_CHECK;
			end
			ppsm_pkg::ST_CHECK: begin
				if (lost)
					state_next = ppsm_pkg::ST_OUT;
				else if (pending_q)
					state_next = ppsm_pkg::ST_RAW_WAIT;
				else
					state_next = ppsm_pkg::ST_SPEED_GO;
			end
			ppsm_pkg::ST_RAW_WAIT: begin
				if (div_done)
					state_next = loaded_q ? ppsm_pkg::ST_FILT_GO : ppsm_pkg::ST_SPEED_GO;
			end
			ppsm_pkg::ST_FILT_GO:   state_next = ppsm_pkg::ST_FILT_WAIT;
			ppsm_pkg::ST_FILT_WAIT: begin
				if (div_done)
					state_next = ppsm_pkg::ST_SPEED_GO;
			end
			ppsm_pkg::ST_SPEED_GO:  state_next = ppsm_pkg::ST_SPEED_WAIT;
			ppsm_pkg::ST_SPEED_WAIT: begin
				if (div_done)
					state_next = ppsm_pkg::ST_OUT;
			end
			ppsm_pkg::ST_OUT: begin
				if (res_ready)
					state_next = ppsm_pkg::ST_IDLE;
			end
			default: state_next = ppsm_pkg::ST_IDLE;
		endcase
	end

	// Outputs and divider requests
	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		div_start = 1'b0;
		div_req   = '0;
		unique case (state_q)
			ppsm_pkg::ST_IDLE: in_ready = 1'b1;
			ppsm_pkg::ST_CHECK: begin
				div_start        = !lost && pending_q;
				div_req.dividend = ppsm_pkg::DIV_W'(raw_num) << (ppsm_pkg::DIV_W - ppsm_pkg::NUM_W);
				div_req.divisor  = ppsm_pkg::DVS_W'(period_q);
				div_req.steps    = ppsm_pkg::STEP_W'(ppsm_pkg::NUM_W);
			end
			ppsm_pkg::ST_FILT_GO: begin
				div_start        = 1'b1;
				div_req.dividend = ppsm_pkg::DIV_W'(filt_sum) << (ppsm_pkg::DIV_W - ppsm_pkg::FILT_W);
				div_req.divisor  = ppsm_pkg::FILT_DIVISOR;
				div_req.steps    = ppsm_pkg::STEP_W'(ppsm_pkg::FILT_W);
			end
			ppsm_pkg::ST_SPEED_GO: begin
				div_start        = 1'b1;
				div_req.dividend = speed_num;
				div_req.divisor  = ppsm_pkg::DVS_W'(ppk_eff);
				div_req.steps    = ppsm_pkg::STEP_W'(ppsm_pkg::DIV_W);
			end
			ppsm_pkg::ST_OUT: res_valid = 1'b1;
			default: ;
		endcase
	end

	// Measurement state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ppsm_pkg::ST_IDLE;
			armed_q        <= 1'b0;
			prev_capture_q <= '0;
			period_q       <= '0;
			capture_time_q <= '0;
			pending_q      <= 1'b0;
			filtered_q     <= '0;
			loaded_q       <= 1'b0;
		end else begin
			state_q <= state_next;
			// Capture edge: arm, or store a nonzero period
			if (accept && in_op == ppsm_pkg::OP_CAPTURE) begin
				if (armed_q) begin
					if (in_capture != prev_capture_q) begin
						period_q       <= in_capture - prev_capture_q;
						capture_time_q <= in_now;
						pending_q      <= 1'b1;
					end
				end else begin
					armed_q        <= 1'b1;
					capture_time_q <= in_now;
				end
				prev_capture_q <= in_capture;
			end
			if (state_q == ppsm_pkg::ST_CHECK && lost)
				loaded_q <= 1'b0;
			// First frequency loads the filter
			if (state_q == ppsm_pkg::ST_RAW_WAIT && div_done && !loaded_q) begin
				filtered_q <= raw_sat;
				loaded_q   <= 1'b1;
				pending_q  <= 1'b0;
			end
			if (state_q == ppsm_pkg::ST_FILT_WAIT && div_done) begin
				filtered_q <= div_quot[ppsm_pkg::FREQ_W-1:0];
				pending_q  <= 1'b0;
			end
		end
	end

	// Request payload and results
	always_ff @(posedge clk) begin
		if (accept)
			now_q <= in_now;
		if (state_q == ppsm_pkg::ST_RAW_WAIT && div_done)
			raw_q <= raw_sat;
		if (state_q == ppsm_pkg::ST_CHECK && lost)
			res_q <= '0;
		if (state_q == ppsm_pkg::ST_SPEED_WAIT && div_done) begin
			res_q.freq_chz   <= ppsm_pkg::clamp16(ppsm_pkg::DIV_W'(filtered_q));
			res_q.speed_ckph <= ppsm_pkg::clamp16(div_quot);
			res_q.has_signal <= 1'b1;
		end
	end

	assign res = res_q;

	ppsm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quot)
	);

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SEGMENT_ITEMS = 213;
	localparam int SETTLE_CYCLES = 150;
	localparam int HOLD_OFF_CYCLES = 600;
	localparam logic [ppsm_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

	// Predicts the meter readings from the accepted captures and requests
	class speed_meter_scoreboard;
		logic [ppsm_pkg::TICK_W-1:0]    tick_rate_hz;
		logic [ppsm_pkg::TIMEOUT_W-1:0] timeout_ms;
		logic [ppsm_pkg::PPK_W-1:0]     pulses_per_km;
		logic                 armed;
		logic [31:0]          prev_capture;
		logic [31:0]          period;
		logic [31:0]          capture_time;
		logic                 pending;
		logic [31:0]          filtered;
		logic                 loaded;
		ppsm_pkg::res_t       expected_readings[$];
		int                   mismatches;

		function new();
			tick_rate_hz = ppsm_pkg::TICK_RESET;
			timeout_ms = ppsm_pkg::TIMEOUT_RESET;
			pulses_per_km = ppsm_pkg::PPK_RESET;
			armed = 1'b0;
			prev_capture = '0;
			period = '0;
			capture_time = '0;
			pending = 1'b0;
			filtered = '0;
			loaded = 1'b0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [ppsm_pkg::CFG_IDX_W-1:0] idx,
				logic [ppsm_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				ppsm_pkg::CFG_TICK_RATE: tick_rate_hz = data[ppsm_pkg::TICK_W-1:0];
				ppsm_pkg::CFG_TIMEOUT:   timeout_ms = data[ppsm_pkg::TIMEOUT_W-1:0];
				ppsm_pkg::CFG_PPK:       pulses_per_km = data[ppsm_pkg::PPK_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_item(logic op, logic [31:0] cap, logic [31:0] now);
			logic [31:0] delta;
			logic [31:0] age;
			logic [63:0] raw;
			logic [63:0] speed;
			logic [63:0] divisor;
			ppsm_pkg::res_t reading;
			// captures update the period tracking and give no reading
			if (op == ppsm_pkg::OP_CAPTURE) begin
				if (armed) begin
					delta = cap - prev_capture;
					if (delta != 0) begin
						period = delta;
						capture_time = now;
						pending = 1'b1;
					end
				end else begin
					armed = 1'b1;
					capture_time = now;
				end
				prev_capture = cap;
				return;
			end
			// signal lost: clear the filter, report zeros, keep the pending period
			age = now - capture_time;
			if (period == 0 || age > 32'(timeout_ms)) begin
				loaded = 1'b0;
				reading = '0;
				expected_readings.push_back(reading);
				return;
			end
			// fold a fresh period into the average
			if (pending) begin
				raw = (64'(tick_rate_hz) * 64'd100 + 64'(period >> 1)) / 64'(period);
				if (raw > 64'hFFFF_FFFF)
					raw = 64'hFFFF_FFFF;
				if (loaded) begin
					filtered = 32'((64'(filtered) * 64'd4 + raw + 64'd2) / 64'd5);
				end else begin
					filtered = raw[31:0];
					loaded = 1'b1;
				end
				pending = 1'b0;
			end
			divisor = (pulses_per_km == 0) ? 64'd1 : 64'(pulses_per_km);
			speed = (64'(filtered) * 64'd3600 + (divisor >> 1)) / divisor;
			reading.freq_chz = (filtered > 32'hFFFF) ? 16'hFFFF : filtered[15:0];
			reading.speed_ckph = (speed > 64'hFFFF) ? 16'hFFFF : speed[15:0];
			reading.has_signal = 1'b1;
			expected_readings.push_back(reading);
		endfunction

		function void check_reading(logic [15:0] freq, logic [15:0] speed, logic present);
			ppsm_pkg::res_t want;
			if (expected_readings.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected reading: expected none, %s %0d speed %0d present %0b",
					$time, "actual freq", freq, speed, present);
				return;
			end
			want = expected_readings.pop_front();
			if (freq !== want.freq_chz || speed !== want.speed_ckph ||
					present !== want.has_signal) begin
				mismatches++;
				$display("%0t: reading mismatch: expected freq %0d speed %0d present %0b,",
					$time, want.freq_chz, want.speed_ckph, want.has_signal);
				$display("%0t: reading mismatch: actual freq %0d speed %0d present %0b",
					$time, freq, speed, present);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [63:0]           s_tdata = '0;  // capture_value[31:0], now_ms[63:32]
	logic                  s_tuser = 1'b0;  // op
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [31:0]           m_tdata;  // freq_chz[15:0], speed_ckph[31:16]
	logic                  m_tuser;  // has_signal
	logic                  cfg_we = 1'b0;
	logic [ppsm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [ppsm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	speed_meter_scoreboard sb = new();
	int          send_idle_pct;
	int          recv_idle_pct;
	int          hold_off_req;
	int unsigned cycles;
	logic [31:0] cur_cap;
	logic [31:0] cur_now;
	logic [15:0] cur_timeout;

	pulse_period_speed_meter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Abort a hung run
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// Drive the result ready, with long hold-offs on request
	initial begin
		int hold_left;
		int holds_seen;
		hold_left = 0;
		holds_seen = 0;
		forever begin
			@(posedge clk);
			if (holds_seen != hold_off_req) begin
				holds_seen = hold_off_req;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Check every reading taken; sampled mid-cycle so all signals are settled
	initial begin
		forever begin
			@(negedge clk);
			if (arst_n && m_tvalid && m_tready)
				sb.check_reading(m_tdata[15:0], m_tdata[31:16], m_tuser);
		end
	end

	task automatic offer_item(input logic op, input logic [31:0] cap, input logic [31:0] now);
		logic taken;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {now, cap};
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		sb.note_item(op, cap, now);
	endtask

	// Drop valid, wait for every reading, then let trailing captures finish
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.expected_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [31:0] tick, input logic [31:0] tmo,
			input logic [31:0] ppk);
		logic [ppsm_pkg::CFG_IDX_W-1:0]  idx[4];
		logic [ppsm_pkg::CFG_DATA_W-1:0] val[4];
		idx = '{ppsm_pkg::CFG_TICK_RATE, ppsm_pkg::CFG_TIMEOUT, ppsm_pkg::CFG_PPK,
			CFG_UNMAPPED};
		val = '{tick, tmo, ppk, $urandom};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			sb.write_reg(idx[i], val[i]);
		end
		cfg_we <= 1'b0;
		cur_timeout = tmo[15:0];
	endtask

	// Mostly within the timeout, sometimes right at it or past it
	function automatic logic [31:0] ms_advance();
		case ($urandom_range(19))
			0: ms_advance = 32'(cur_timeout) + 32'd1 + $urandom_range(5000);
			1: ms_advance = 32'(cur_timeout);
			2: ms_advance = $urandom;
			default: ms_advance = $urandom_range(32'(cur_timeout));
		endcase
	endfunction

	// Bursts of captures at one rate followed by requests, mixed with noise
	task automatic run_segment(input int n_items);
		int sent;
		logic [31:0] base;
		logic [31:0] step;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 20) begin
				offer_item(1'($urandom_range(1)), $urandom, $urandom);
				sent++;
				if ($urandom_range(3) == 0) begin
					cur_now = $urandom;
					cur_cap = $urandom;
				end
			end else begin
				case ($urandom_range(4))
					0: base = $urandom_range(64, 1);
					1: base = $urandom_range(20000, 1000);
					2: base = $urandom_range(2000000, 20000);
					3: base = $urandom;
					default: base = '0;
				endcase
				repeat ($urandom_range(4, 1)) begin
					step = base + ((base >= 32'd16) ? $urandom_range(base >> 4) : 32'd0);
					cur_cap = cur_cap + step;
					cur_now = cur_now + ms_advance();
					offer_item(ppsm_pkg::OP_CAPTURE, cur_cap, cur_now);
					sent++;
				end
				repeat ($urandom_range(2, 1)) begin
					cur_now = cur_now + ms_advance();
					offer_item(ppsm_pkg::OP_REQUEST, $urandom, cur_now);
					sent++;
				end
			end
		end
	endtask

	initial begin
		send_idle_pct = 13;
		recv_idle_pct = 78;
		hold_off_req = 0;
		cur_cap = $urandom;
		cur_now = $urandom;
		cur_timeout = ppsm_pkg::TIMEOUT_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: no signal yet, arming, wrapped counts and times
		offer_item(ppsm_pkg::OP_REQUEST, 32'hFFFF_FFFF, 32'h0);
		offer_item(ppsm_pkg::OP_CAPTURE, 32'hFFFF_FFF0, 32'h0);
		offer_item(ppsm_pkg::OP_REQUEST, 32'h0, 32'd5);
		offer_item(ppsm_pkg::OP_CAPTURE, 32'h0000_0010, 32'd5);
		offer_item(ppsm_pkg::OP_REQUEST, 32'h0, 32'd5);
		offer_item(ppsm_pkg::OP_REQUEST, 32'h0, 32'd10);
		offer_item(ppsm_pkg::OP_CAPTURE, 32'h0000_0010, 32'd20);
		offer_item(ppsm_pkg::OP_REQUEST, 32'h0, 32'd1005);
		offer_item(ppsm_pkg::OP_REQUEST, 32'h0, 32'd1006);
		offer_item(ppsm_pkg::OP_CAPTURE, 32'd100016, 32'd2000);
		offer_item(ppsm_pkg::OP_REQUEST, 32'h0, 32'd2000);
		offer_item(ppsm_pkg::OP_CAPTURE, 32'd150016, 32'd2010);
		offer_item(ppsm_pkg::OP_REQUEST, 32'h0, 32'd2020);
		offer_item(ppsm_pkg::OP_CAPTURE, 32'd156016, 32'hFFFF_FFF0);
		offer_item(ppsm_pkg::OP_REQUEST, 32'h0, 32'h0000_0010);
		offer_item(ppsm_pkg::OP_CAPTURE, 32'd156015, 32'h20);
		offer_item(ppsm_pkg::OP_REQUEST, 32'h0, 32'h20);

		// fastest clock, one- and two-tick periods, masked timeout and zero pulses per km
		wait_idle();
		program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFF0_0000);
		offer_item(ppsm_pkg::OP_CAPTURE, 32'h8000_0000, 32'd100);
		offer_item(ppsm_pkg::OP_CAPTURE, 32'h8000_0001, 32'd100);
		offer_item(ppsm_pkg::OP_REQUEST, 32'h0, 32'd65635);
		offer_item(ppsm_pkg::OP_CAPTURE, 32'h8000_0003, 32'd200);
		offer_item(ppsm_pkg::OP_REQUEST, 32'h0, 32'd200);

		// stopped timer
		wait_idle();
		program_regs(32'd0, 32'd1000, 32'd1000000);
		offer_item(ppsm_pkg::OP_CAPTURE, 32'h8000_1003, 32'd300);
		offer_item(ppsm_pkg::OP_REQUEST, 32'h0, 32'd300);

		for (int seg = 0; seg < 6; seg++) begin
			wait_idle();
			case (seg / 2)
				0: begin
					send_idle_pct = 13;
					recv_idle_pct = 78;
				end
				1: begin
					send_idle_pct = 78;
					recv_idle_pct = 13;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			case (seg)
				0: program_regs(32'd1000000, 32'd1000, 32'd1000);
				1: program_regs(32'd1, 32'd65535, 32'd1000000);
				2: program_regs(32'hFFFF_FFFF, 32'd0, 32'd1);
				3: program_regs($urandom_range(10000000, 100000), $urandom_range(65535),
					$urandom_range(4095) << 20);
				4: program_regs($urandom, $urandom, $urandom);
				default: program_regs(32'd1000000, 32'd250, 32'd2500);
			endcase
			cur_cap = $urandom;
			// hold the readings back so the block backs up into its input
			if (seg == 2 || seg == 4)
				hold_off_req++;
			run_segment(SEGMENT_ITEMS);
		end

		wait_idle();
		if (sb.mismatches == 0 && sb.expected_readings.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
